// ===== rtl/core/bfda_pkg.sv =====
package bfda_pkg;

    localparam int unsigned CHARS_PER_RUN = 6;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned IDX_W         = 3;

    // Values at or above this round past 999.99
    localparam logic [31:0] OVF_LIMIT  = 32'd255999;
    // 1000/256 reduced to 125/32
    localparam logic [24:0] SCALE_NUM  = 25'd125;
    localparam int unsigned SCALE_SHIFT = 5;
    localparam logic [19:0] ROUND_HALF = 20'd5;

    // floor(x/10) = (x * ceil(2^24/10)) >> 24, exact for x < 2^22
    localparam logic [40:0] DIV10_MUL   = 41'd1677722;
    localparam int unsigned DIV10_SHIFT = 24;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_STAR  = 8'h2A;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        logic                          overflow;
        logic [CHARS_PER_RUN-1:0][7:0] chars;   // chars[0] is shown first
    } bfda_text_t;

    function automatic logic [16:0] div10(input logic [19:0] x);
        logic [40:0] p;
        p = {21'b0, x} * DIV10_MUL;
        return p[DIV10_SHIFT+16:DIV10_SHIFT];
    endfunction

    // x - 10*q, where q = floor(x/10); only the low nibble is meaningful
    function automatic logic [3:0] rem10(input logic [19:0] x, input logic [19:0] q);
        logic [19:0] t;
        t = x - ((q << 3) + (q << 1));
        return t[3:0];
    endfunction

endpackage

// ===== rtl/core/bfda_conv.sv =====
module bfda_conv
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         value,
    output logic                text_valid,
    input  logic                text_ready,
    output bfda_pkg::bfda_text_t text
);
    import bfda_pkg::*;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    // stage payloads
    logic        ovf1_reg, ovf2_reg, ovf3_reg, ovf4_reg, ovf5_reg;
    logic [19:0] q1_reg;          // floor(v*125/32)
    logic [16:0] r2_reg;          // rounded hundredths
    logic [13:0] r3_reg;          // r/10
    logic [10:0] r4_reg;          // r/100
    logic [7:0]  r5_reg;          // r/1000
    logic [3:0]  d4_3_reg, d4_4_reg, d4_5_reg;
    logic [3:0]  d3_4_reg, d3_5_reg;
    logic [3:0]  d2_5_reg;
    bfda_text_t  text_reg;

    logic [24:0] prod1;
    logic [19:0] q1_next;
    logic [19:0] x2;
    logic [16:0] r2_next;
    logic [16:0] quo3, quo4, quo5, quo6;
    logic [3:0]  d0, d1;
    logic        hundreds_blank;
    bfda_text_t  text_next;

    assign rdy6     = !v6_reg || text_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // only the low 18 bits matter when the value is in range
    assign prod1   = {7'b0, value[17:0]} * SCALE_NUM;
    assign q1_next = prod1[SCALE_SHIFT+19:SCALE_SHIFT];

    assign x2      = q1_reg + ROUND_HALF;
    assign r2_next = div10(x2);

    assign quo3 = div10({3'b0, r2_reg});
    assign quo4 = div10({6'b0, r3_reg});
    assign quo5 = div10({9'b0, r4_reg});
    assign quo6 = div10({12'b0, r5_reg});
    assign d0   = quo6[3:0];
    assign d1   = rem10({12'b0, r5_reg}, {3'b0, quo6});

    always_comb
    begin
        hundreds_blank     = (d0 == 4'd0);
        text_next.overflow = ovf5_reg;
        if (ovf5_reg)
        begin
            text_next.chars[0] = ASCII_STAR;
            text_next.chars[1] = ASCII_STAR;
            text_next.chars[2] = ASCII_STAR;
            text_next.chars[3] = ASCII_DOT;
            text_next.chars[4] = ASCII_STAR;
            text_next.chars[5] = ASCII_STAR;
        end
        else
        begin
            text_next.chars[0] = hundreds_blank ? ASCII_SPACE : (ASCII_ZERO | {4'b0, d0});
            text_next.chars[1] = (hundreds_blank && d1 == 4'd0) ? ASCII_SPACE
                                                                 : (ASCII_ZERO | {4'b0, d1});
            text_next.chars[2] = ASCII_ZERO | {4'b0, d2_5_reg};
            text_next.chars[3] = ASCII_DOT;
            text_next.chars[4] = ASCII_ZERO | {4'b0, d3_5_reg};
            text_next.chars[5] = ASCII_ZERO | {4'b0, d4_5_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            q1_reg   <= q1_next;
            ovf1_reg <= (value >= OVF_LIMIT);
        end
        if (rdy2 && v1_reg)
        begin
            r2_reg   <= r2_next;
            ovf2_reg <= ovf1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            r3_reg   <= quo3[13:0];
            d4_3_reg <= rem10({3'b0, r2_reg}, {3'b0, quo3});
            ovf3_reg <= ovf2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            r4_reg   <= quo4[10:0];
            d3_4_reg <= rem10({6'b0, r3_reg}, {3'b0, quo4});
            d4_4_reg <= d4_3_reg;
            ovf4_reg <= ovf3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            r5_reg   <= quo5[7:0];
            d2_5_reg <= rem10({9'b0, r4_reg}, {3'b0, quo5});
            d3_5_reg <= d3_4_reg;
            d4_5_reg <= d4_4_reg;
            ovf5_reg <= ovf4_reg;
        end
        if (rdy6 && v5_reg)
        begin
            text_reg <= text_next;
        end
    end

    assign text_valid = v6_reg;
    assign text       = text_reg;

endmodule

// ===== rtl/core/binary_fixed_to_decimal_ascii.sv =====
// Path: an accepted value runs through six conversion stages, then into the serializer.
// Throughput: the character serializer sends one character per cycle while
// m_axis_tready is high, and each value yields six. The 6-stage conversion
// pipeline takes a value every cycle until it fills behind the serializer.
// Reset: rst_n clears all valid bits and the serializer count; no output is pending.
module binary_fixed_to_decimal_ascii
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] character
    output logic        m_axis_tlast,   // last character of the run
    output logic        m_axis_tuser    // [0] overflow
);
    import bfda_pkg::*;

    // Pipeline: floor(v*125/32) -> round to hundredths -> three digit peels by
    // reciprocal multiply -> last two digits and ASCII formatting.
    logic       text_valid;
    logic       text_ready;
    bfda_text_t text;

    bfda_conv u_conv
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .value      (s_axis_tdata),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text)
    );

    // Serializer: a shift register of six characters; the head always drives tdata,
    // so the output comes straight from flops.
    logic                          busy_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [CHARS_PER_RUN-1:0][7:0] chars_reg;
    logic                          ovf_reg;
    logic                          at_last;
    logic                          out_fire;
    logic                          load;

    assign at_last    = (idx_reg == IDX_W'(CHARS_PER_RUN - 1));
    assign out_fire   = busy_reg && m_axis_tready;
    // take the next run when empty or while the final character leaves
    assign text_ready = !busy_reg || (out_fire && at_last);
    assign load       = text_ready && text_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (out_fire)
            begin
                if (at_last)
                begin
                    busy_reg <= 1'b0;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= text.chars;
            ovf_reg   <= text.overflow;
        end
        else if (out_fire)
        begin
            chars_reg <= {8'h00, chars_reg[CHARS_PER_RUN-1:1]};
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = chars_reg[0];
    assign m_axis_tlast  = at_last;
    assign m_axis_tuser  = ovf_reg;

endmodule
